// ===== src/tvp_pkg.sv =====
// Types, codes and constants shared by the vibration pattern block.
package tvp_pkg;

  localparam logic [7:0] UNIT_RESET = 8'd100;

  localparam logic [3:0] DIGIT_MAX  = 4'd9;
  localparam logic [3:0] LONG_BASE  = 4'd5;
  localparam logic [3:0] LONG_FIRST = 4'd6;

  localparam logic [2:0] LEN_ZERO  = 3'd5;
  localparam logic [2:0] LEN_SHORT = 3'd1;
  localparam logic [2:0] LEN_LONG  = 3'd3;

  localparam logic [2:0] GAP_PULSE = 3'd1;
  localparam logic [2:0] GAP_DIGIT = 3'd3;
  localparam logic [2:0] GAP_HOUR  = 3'd7;

  typedef struct packed {
    logic       two_digit_hour;
    logic [3:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
  } in_item_t;

  typedef struct packed {
    logic [10:0] duration;
    logic        motor_on;
    logic        last_segment;
  } out_item_t;

  typedef struct packed {
    logic [2:0] pulses;
    logic [2:0] len;
    logic [2:0] gap;
    logic       last;
  } digit_cmd_t;

  typedef enum logic [1:0] {
    DIG_HOUR_TENS,
    DIG_HOUR_ONES,
    DIG_MINUTE_TENS,
    DIG_MINUTE_ONES
  } digit_sel_t;

  typedef enum logic {
    FR_IDLE,
    FR_EMIT
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PULSE,
    BK_GAP
  } back_state_t;

endpackage

// ===== src/tvp_front.sv =====
// Front end: accepts a time item and splits it into per-digit pulse commands.
module tvp_front
  import tvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       push,
  output digit_cmd_t push_cmd,
  input  logic       full
);

  front_state_t state, state_next;
  in_item_t     item;
  digit_sel_t   sel;
  logic [3:0]   digit;
  logic [3:0]   clamped;
  logic         accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (in_valid) state_next = FR_EMIT;
      end
      FR_EMIT: begin
        if (!full && sel == DIG_MINUTE_ONES) state_next = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != FR_IDLE);
    push     = (state == FR_EMIT) && !full;
  end

  always_comb begin
    unique case (sel)
      DIG_HOUR_TENS:   digit = item.hour_tens;
      DIG_HOUR_ONES:   digit = item.hour_ones;
      DIG_MINUTE_TENS: digit = {1'b0, item.minute_tens};
      DIG_MINUTE_ONES: digit = item.minute_ones;
      default:         digit = item.minute_ones;
    endcase
    clamped = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
    priority if (clamped == 4'd0) begin
      push_cmd.pulses = 3'd1;
      push_cmd.len    = LEN_ZERO;
    end else if (clamped < LONG_FIRST) begin
      push_cmd.pulses = clamped[2:0];
      push_cmd.len    = LEN_SHORT;
    end else begin
      push_cmd.pulses = 3'(clamped - LONG_BASE);
      push_cmd.len    = LEN_LONG;
    end
    push_cmd.gap  = (sel == DIG_HOUR_ONES) ? GAP_HOUR : GAP_DIGIT;
    push_cmd.last = (sel == DIG_MINUTE_ONES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
      sel   <= DIG_HOUR_TENS;
    end else begin
      state <= state_next;
      if (accept) begin
        sel <= in_item.two_digit_hour ? DIG_HOUR_TENS : DIG_HOUR_ONES;
      end else if (push) begin
        sel <= digit_sel_t'(sel + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item <= in_item;
  end

endmodule

// ===== src/tvp_queue.sv =====
// Short command queue between front end and segment sequencer.
module tvp_queue
  import tvp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  digit_cmd_t push_cmd,
  output logic       full,
  input  logic       pop,
  output digit_cmd_t pop_cmd,
  output logic       not_empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [PW-1:0] PTR_STEP = PW'(1);
  localparam logic [CW-1:0] CNT_STEP = CW'(1);

  digit_cmd_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_STEP;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_STEP;
      if (do_push && !do_pop)      count <= count + CNT_STEP;
      else if (do_pop && !do_push) count <= count - CNT_STEP;
    end
  end

endmodule

// ===== src/tvp_back.sv =====
// Segment sequencer: expands digit commands into timed on/off segments.
module tvp_back
  import tvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] unit_duration,
  input  logic       cmd_valid,
  input  digit_cmd_t cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  back_state_t state, state_next;
  digit_cmd_t  cur;
  logic [2:0]  remain;
  logic        load;
  logic        emit;
  logic [2:0]  seg_units;
  logic        seg_motor;
  logic        seg_last;
  logic        final_pulse;

  assign load        = !out_valid || !out_stall;
  assign final_pulse = (remain == 3'd1);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) state_next = BK_PULSE;
      end
      BK_PULSE: begin
        if (load) state_next = (cur.last && final_pulse) ? BK_IDLE : BK_GAP;
      end
      BK_GAP: begin
        if (load) state_next = final_pulse ? BK_IDLE : BK_PULSE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    seg_units = cur.len;
    seg_motor = 1'b1;
    seg_last  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        pop = cmd_valid;
      end
      BK_PULSE: begin
        emit     = load;
        seg_last = cur.last && final_pulse;
      end
      BK_GAP: begin
        emit      = load;
        seg_motor = 1'b0;
        seg_units = final_pulse ? cur.gap : GAP_PULSE;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit)            out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur    <= cmd;
      remain <= cmd.pulses;
    end else if (emit && state == BK_GAP) begin
      remain <= remain - 3'd1;
    end
    if (emit) begin
      out_item.duration     <= 11'(seg_units) * 11'(unit_duration);
      out_item.motor_on     <= seg_motor;
      out_item.last_segment <= seg_last;
    end
  end

endmodule

// ===== src/time_to_vibration_pattern.sv =====
// Top level: clock time to vibration on/off segment pattern.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_item  (in_item_t)
//   out      output     out_valid / out_stall out_item (out_item_t)
//   cfg      input      cfg_valid / cfg_ready cfg_data (unit duration, 8 bits)
//
// One segment leaves per cycle while out_stall is low; an item gives up to 39
// segments, and the sequencer passes through idle to pop each digit command.
// The front end splits an item into up to four digit commands and takes the
// next item while the queue still drains. Reset empties the queue,
// drops any pending segment and sets the unit duration to 100 ms.
// out_stall holds the output register and backs up queue and input in turn.
module time_to_vibration_pattern
  import tvp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] unit_duration;
  logic       q_push;
  digit_cmd_t q_push_cmd;
  logic       q_full;
  logic       q_pop;
  digit_cmd_t q_pop_cmd;
  logic       q_not_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_duration <= UNIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unit_duration <= cfg_data;
    end
  end

  tvp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full)
  );

  tvp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_pop_cmd),
    .not_empty (q_not_empty)
  );

  tvp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .unit_duration (unit_duration),
    .cmd_valid     (q_not_empty),
    .cmd           (q_pop_cmd),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("digit command pushed into a full queue");

  a_last_is_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.last_segment |-> out_item.motor_on)
    else $error("final segment is a pause");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("front end took a second item before splitting the first");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty)
    else $error("sequencer popped an empty queue");
`endif

endmodule
